### hw/rtl/swrs_pkg.sv
// ----------------------------------------------------------------------------
// swrs_pkg
// Shared types and codes for the swap-remove stack.
// ----------------------------------------------------------------------------
package swrs_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = ADDR_W + 1;

   typedef logic [2:0]            op_type;
   typedef logic [1:0]            status_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic signed [31:0]    value_type;

   // operation codes
   localparam op_type OP_PUSH   = 3'd0;
   localparam op_type OP_PUSHB  = 3'd1;
   localparam op_type OP_POP    = 3'd2;
   localparam op_type OP_POPN   = 3'd3;
   localparam op_type OP_POPB   = 3'd4;
   localparam op_type OP_ERASE  = 3'd5;
   localparam op_type OP_CLEAR  = 3'd6;

   // status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_OVER   = 2'd1;
   localparam status_type ST_UNDER  = 2'd2;
   localparam status_type ST_BADPOS = 2'd3;

   localparam cnt_type CAP_RESET = CNT_W'(DEPTH);

endpackage

### hw/rtl/swap_remove_stack.sv
// ----------------------------------------------------------------------------
// swap_remove_stack
// Array stack with push, push-bottom, pop, pop-many, pop-bottom, erase and
// clear, held in one single-port synchronous RAM.
// ----------------------------------------------------------------------------
// Push writes its word; push bottom on a non-empty stack moves slot 0 on top,
// then writes slot 0; pop bottom and erase move the top word into the freed
// slot; these, pop, pop many, clear, unused codes and refused requests read
// the new top (one RAM access a cycle). One request in flight, the next taken
// once the response is registered. Reset: depth 0, capacity 1024, no response
// pending; RAM not swept, a high-water mark reads never-written slots as zero.
// ----------------------------------------------------------------------------
module swap_remove_stack (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swrs_pkg::op_type       req_operation,
   input  swrs_pkg::value_type    req_value,
   input  swrs_pkg::cnt_type      req_drop_count,
   input  swrs_pkg::addr_type     req_position,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swrs_pkg::value_type    rsp_top_value,
   output swrs_pkg::cnt_type      rsp_depth,
   output swrs_pkg::status_type   rsp_status,
   // capacity register
   input  logic                   csr_wr_en,
   input  swrs_pkg::cnt_type      csr_wr_data
);
   import swrs_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_PUSH  = 3'd1;  // write the pushed word
   localparam logic [2:0] ST_MOVE  = 3'd2;  // source word arrived, write it
   localparam logic [2:0] ST_PUT0  = 3'd3;  // push bottom: new word to slot 0
   localparam logic [2:0] ST_RDTOP = 3'd4;  // read the new top slot
   localparam logic [2:0] ST_TOPD  = 3'd5;  // top word arrived
   localparam logic [2:0] ST_HOLD  = 3'd6;  // response register busy

   // what a request does to the RAM
   localparam logic [1:0] ACT_TOP   = 2'd0;  // no write, just read the top
   localparam logic [1:0] ACT_PUSH  = 2'd1;  // one write
   localparam logic [1:0] ACT_PUSHB = 2'd2;  // read slot 0, two writes
   localparam logic [1:0] ACT_MOVE  = 2'd3;  // move top word, read new top

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   logic [2:0] state_ff, state_in;
   cnt_type    fill_ff;      // entries held
   cnt_type    hwm_ff;       // slots below this were written since reset
   cnt_type    capacity_ff;
   status_type status_ff;
   addr_type   dst_ff;       // write target of the first write
   word_type   val_ff;       // request word
   logic       pushb_ff;
   word_type   top_ff, top_in;

   word_type   mem [DEPTH];
   word_type   mem_rdata_ff;
   logic       rd_zero_ff;   // last read hit a never-written slot

   logic       rsp_valid_ff;
   value_type  rsp_top_ff;
   cnt_type    rsp_depth_ff;
   status_type rsp_status_ff;

   // ------------------------------------------------------------------
   // Request decode, evaluated against the current depth
   // ------------------------------------------------------------------
   logic       req_accept;
   cnt_type    limit;
   logic       full, empty;
   status_type dec_status;
   logic [1:0] dec_act;
   cnt_type    dec_fill;
   addr_type   dec_dst;
   addr_type   dec_top_idx;
   addr_type   src_idx;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign limit   = (capacity_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_ff;
   assign full    = (fill_ff >= limit);
   assign empty   = (fill_ff == '0);
   assign src_idx = ADDR_W'(fill_ff - CNT_W'(1));   // current top slot

   always_comb begin
      dec_status = ST_OK;
      dec_act    = ACT_TOP;
      dec_fill   = fill_ff;
      dec_dst    = '0;
      unique case (req_operation)
         OP_PUSH: begin
            if (full) begin
               dec_status = ST_OVER;
            end else begin
               dec_act  = ACT_PUSH;
               dec_dst  = ADDR_W'(fill_ff);
               dec_fill = fill_ff + CNT_W'(1);
            end
         end
         OP_PUSHB: begin
            if (full) begin
               dec_status = ST_OVER;
            end else begin
               // on an empty stack this is a plain push into slot 0
               dec_act  = empty ? ACT_PUSH : ACT_PUSHB;
               dec_dst  = ADDR_W'(fill_ff);
               dec_fill = fill_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (empty) begin
               dec_status = ST_UNDER;
            end else begin
               dec_fill = fill_ff - CNT_W'(1);
            end
         end
         OP_POPN: begin
            if (req_drop_count > fill_ff) begin
               dec_status = ST_UNDER;
            end else begin
               dec_fill = fill_ff - req_drop_count;
            end
         end
         OP_POPB: begin
            if (empty) begin
               dec_status = ST_UNDER;
            end else begin
               dec_act  = ACT_MOVE;
               dec_dst  = '0;
               dec_fill = fill_ff - CNT_W'(1);
            end
         end
         OP_ERASE: begin
            if (empty) begin
               dec_status = ST_UNDER;
            end else if (req_position == '0 || {1'b0, req_position} >= fill_ff) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_act  = ACT_MOVE;
               dec_dst  = req_position;
               dec_fill = fill_ff - CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            dec_fill = '0;
         end
         default: begin
            // unused code: no change
         end
      endcase
   end

   assign dec_top_idx = (dec_fill == '0) ? '0 : ADDR_W'(dec_fill - CNT_W'(1));

   // ------------------------------------------------------------------
   // Sequencer: one RAM access per cycle
   // ------------------------------------------------------------------
   logic     mem_we, mem_re;
   addr_type mem_addr;
   word_type mem_wdata;
   word_type rd_word;
   word_type top_now;
   logic     finish;
   logic     rsp_free;
   logic     load_rsp;
   addr_type cur_top_idx;

   assign rd_word     = rd_zero_ff ? '0 : mem_rdata_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign cur_top_idx = (fill_ff == '0) ? '0 : src_idx;

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      top_now   = top_ff;
      finish    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (dec_act)
                  ACT_TOP: begin
                     mem_re   = 1'b1;
                     mem_addr = dec_top_idx;
                     state_in = ST_TOPD;
                  end
                  ACT_PUSH: begin
                     state_in = ST_PUSH;
                  end
                  ACT_PUSHB: begin
                     mem_re   = 1'b1;
                     mem_addr = '0;
                     state_in = ST_MOVE;
                  end
                  default: begin   // ACT_MOVE
                     mem_re   = 1'b1;
                     mem_addr = src_idx;
                     state_in = ST_MOVE;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            mem_we    = 1'b1;
            mem_addr  = dst_ff;
            mem_wdata = val_ff;
            top_now   = val_ff;
            finish    = 1'b1;
         end
         ST_MOVE: begin
            // push bottom: old slot 0 goes on top and becomes the top word
            mem_we    = 1'b1;
            mem_addr  = dst_ff;
            mem_wdata = rd_word;
            top_in    = rd_word;
            state_in  = pushb_ff ? ST_PUT0 : ST_RDTOP;
         end
         ST_PUT0: begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = val_ff;
            top_now   = top_ff;
            finish    = 1'b1;
         end
         ST_RDTOP: begin
            mem_re   = 1'b1;
            mem_addr = cur_top_idx;
            state_in = ST_TOPD;
         end
         ST_TOPD: begin
            top_now = rd_word;
            finish  = 1'b1;
         end
         ST_HOLD: begin
            top_now = top_ff;
            finish  = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (rsp_free) begin
            load_rsp = 1'b1;
            state_in = ST_IDLE;
         end else begin
            top_in   = top_now;
            state_in = ST_HOLD;
         end
      end
   end

   // ------------------------------------------------------------------
   // RAM: single port, registered read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_addr];
         rd_zero_ff   <= ({1'b0, mem_addr} >= hwm_ff);
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         hwm_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            fill_ff <= dec_fill;
         end
         if (mem_we && ({1'b0, mem_addr} >= hwm_ff)) begin
            hwm_ff <= CNT_W'(mem_addr) + CNT_W'(1);
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (req_accept) begin
         status_ff <= dec_status;
         dst_ff    <= dec_dst;
         val_ff    <= DATA_WIDTH'(req_value);
         pushb_ff  <= (dec_act == ACT_PUSHB);
      end
      if (load_rsp) begin
         rsp_top_ff    <= value_type'(top_now);
         rsp_depth_ff  <= fill_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("RAM read and write in the same cycle");

   // a push raises the depth before its write lands, so the
   // written-slot bound is checked between requests only
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= CNT_W'(DEPTH)) && ((state_ff != ST_IDLE) || (fill_ff <= hwm_ff)))
      else $error("depth beyond RAM or beyond written slots");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request taken while previous one still in progress");

endmodule

### verif/tb_stack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_pkg
// Shadow copy of the swap-remove stack: tracks the words, the depth and the
// capacity, predicts each response and checks what the block returns.
// ----------------------------------------------------------------------------
package tb_stack_pkg;
   import swrs_pkg::*;

   localparam op_type OP_SPARE = 3'd7;   // unused code, no effect

   typedef struct packed {
      value_type  top_value;
      cnt_type    depth;
      status_type status;
   } stack_result_type;

   class stack_shadow;
      word_type         slots [DEPTH];
      int unsigned      fill;
      int unsigned      capacity;
      stack_result_type pending_results [$];
      int unsigned      errors;
      int unsigned      checked;

      function new();
         foreach (slots[i]) slots[i] = '0;
         fill     = 0;
         capacity = DEPTH;
         errors   = 0;
         checked  = 0;
      endfunction

      function void set_capacity(cnt_type cap);
         capacity = cap;
      endfunction

      // apply one accepted request and queue the response it must produce
      function void apply_request(op_type op, value_type value, cnt_type drop,
                                  addr_type pos);
         int unsigned      limit;
         stack_result_type r;
         limit    = (capacity < DEPTH) ? capacity : DEPTH;
         r.status = ST_OK;
         case (op)
            OP_PUSH: begin
               if (fill >= limit) begin
                  r.status = ST_OVER;
               end else begin
                  slots[fill] = word_type'(value);
                  fill++;
               end
            end
            OP_PUSHB: begin
               if (fill >= limit) begin
                  r.status = ST_OVER;
               end else begin
                  if (fill != 0) slots[fill] = slots[0];
                  slots[0] = word_type'(value);
                  fill++;
               end
            end
            OP_POP: begin
               if (fill == 0) r.status = ST_UNDER;
               else fill--;
            end
            OP_POPN: begin
               if (drop > fill) r.status = ST_UNDER;
               else fill -= drop;
            end
            OP_POPB: begin
               if (fill == 0) begin
                  r.status = ST_UNDER;
               end else begin
                  fill--;
                  slots[0] = slots[fill];
               end
            end
            OP_ERASE: begin
               if (fill == 0) begin
                  r.status = ST_UNDER;
               end else if (pos == 0 || pos >= fill) begin
                  r.status = ST_BADPOS;
               end else begin
                  fill--;
                  slots[pos] = slots[fill];
               end
            end
            OP_CLEAR: begin
               fill = 0;
            end
            default: begin
            end
         endcase
         r.depth     = cnt_type'(fill);
         r.top_value = value_type'((fill == 0) ? slots[0] : slots[fill - 1]);
         pending_results.push_back(r);
      endfunction

      function void match_response(value_type top, cnt_type depth, status_type status);
         stack_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: top_value %0d depth %0d status %0d",
                     $time, top, depth, status);
            return;
         end
         want = pending_results.pop_front();
         if (top !== want.top_value) begin
            errors++;
            $display("%0t: top_value expected %0d actual %0d", $time, want.top_value, top);
         end
         if (depth !== want.depth) begin
            errors++;
            $display("%0t: depth expected %0d actual %0d", $time, want.depth, depth);
         end
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
      endfunction
   endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the swap-remove stack. A directed pass walks the edge cases
// (empty, full, bad slots, clear, unused code), then random phases sweep the
// capacity with idle bursts switched on and off per side. A shadow copy
// predicts every response; responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import swrs_pkg::*;
   import tb_stack_pkg::*;

   localparam int HOLD_AFTER   = 100;  // responses seen before the long hold-off
   localparam int HOLD_CYCLES  = 400;  // length of the long hold-off
   localparam int SETTLE       = 6;
   localparam int DRAIN_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   op_type     req_operation;
   value_type  req_value;
   cnt_type    req_drop_count;
   addr_type   req_position;
   logic       rsp_valid;
   logic       rsp_stall;
   value_type  rsp_top_value;
   cnt_type    rsp_depth;
   status_type rsp_status;
   logic       csr_wr_en;
   cnt_type    csr_wr_data;

   // idle bursts on each side; both switched off for the last part
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   stack_shadow shadow = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   swap_remove_stack i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_drop_count (req_drop_count),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_top_value  (rsp_top_value),
      .rsp_depth      (rsp_depth),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // Offer one request, maybe after an idle burst, and hold it until taken.
   // The shadow is updated at the accepting edge, so its depth always
   // reflects every request the block has taken.
   task automatic send_request(op_type op, value_type value, cnt_type drop,
                               addr_type pos);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_value      <= value;
      req_drop_count <= drop;
      req_position   <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.apply_request(op, value, drop, pos);
   endtask

   // Capacity changes only with the block idle: every response in, then a
   // settling wait.
   task automatic write_capacity(cnt_type cap);
      req_valid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.set_capacity(cap);
   endtask

   // One random request. push_weight (percent) steers the depth: high values
   // fill the stack, low values keep it shallow. Drops and erase slots mostly
   // land inside the current depth so that most requests do real work.
   task automatic random_request(int push_weight);
      op_type      op;
      value_type   value;
      cnt_type     drop;
      addr_type    pos;
      int unsigned k;
      value = $urandom;
      if ($urandom_range(0, 9) < 7) drop = cnt_type'($urandom_range(0, shadow.fill));
      else drop = cnt_type'($urandom_range(0, 2047));
      if (shadow.fill >= 2 && $urandom_range(0, 3) != 0) begin
         pos = addr_type'($urandom_range(1, shadow.fill - 1));
      end else begin
         pos = addr_type'($urandom_range(0, 1023));
      end
      if ($urandom_range(0, 99) < push_weight) begin
         op = ($urandom_range(0, 4) == 0) ? OP_PUSHB : OP_PUSH;
      end else begin
         k = $urandom_range(0, 19);
         if (k < 5) op = OP_POP;
         else if (k < 8) op = OP_POPN;
         else if (k < 12) op = OP_POPB;
         else if (k < 18) op = OP_ERASE;
         else if (k == 18) op = OP_CLEAR;
         else op = OP_SPARE;
      end
      send_request(op, value, drop, pos);
   endtask

   // Response side: check every accepted response, stall in random bursts,
   // and once hold off for a long stretch so the block backs up.
   initial begin
      int unsigned stall_left;
      bit          hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            shadow.match_response(rsp_top_value, rsp_depth, rsp_status);
         end
         if (!hold_done && shadow.checked == HOLD_AFTER) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus
   initial begin
      int      k;
      cnt_type cap;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operation  <= OP_PUSH;
      req_value      <= '0;
      req_drop_count <= '0;
      req_position   <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty stack, capacity at reset value ---
      send_request(OP_POP,   '0, '0, '0);            // underflow
      send_request(OP_POPB,  '0, '0, '0);            // underflow
      send_request(OP_ERASE, '0, '0, 10'd1023);      // empty wins over bad slot
      send_request(OP_POPN,  '0, 11'd0, '0);         // zero drop is fine
      send_request(OP_POPN,  '0, 11'd1, '0);         // too many
      send_request(OP_SPARE, 32'sh5a5a_5a5a, 11'd2047, 10'd1023);
      send_request(OP_PUSHB, 32'sh8000_0000, '0, '0); // push bottom on empty
      send_request(OP_PUSH,  32'sh7fff_ffff, '0, '0);
      send_request(OP_PUSH,  -32'sd1, '0, '0);
      send_request(OP_PUSH,  32'sd0, '0, '0);
      send_request(OP_PUSHB, 32'sh1234_5678, '0, '0); // old bottom goes on top
      send_request(OP_ERASE, '0, '0, 10'd0);          // slot zero refused
      send_request(OP_ERASE, '0, '0, addr_type'(shadow.fill)); // past the top
      send_request(OP_ERASE, '0, '0, 10'd1023);
      send_request(OP_ERASE, '0, '0, 10'd1);
      send_request(OP_POPB,  '0, '0, '0);
      send_request(OP_POPN,  '0, 11'd2047, '0);
      send_request(OP_POPN,  '0, 11'd1, '0);
      send_request(OP_CLEAR, '0, '0, '0);             // top shows slot zero
      send_request(OP_POP,   '0, '0, '0);

      // capacity zero refuses every push, capacity one takes exactly one
      write_capacity(11'd0);
      send_request(OP_PUSH,  32'sd77, '0, '0);
      send_request(OP_PUSHB, 32'sd78, '0, '0);
      write_capacity(11'd1);
      send_request(OP_PUSHB, 32'sd79, '0, '0);
      send_request(OP_PUSH,  32'sd80, '0, '0);
      send_request(OP_PUSHB, 32'sd81, '0, '0);

      // --- fill to the physical depth with the register above it ---
      write_capacity(11'd2047);
      repeat (600) random_request(95);
      while (shadow.fill < DEPTH) begin
         send_request(OP_PUSH, $urandom, cnt_type'($urandom), addr_type'($urandom));
      end
      repeat (60) random_request(60);   // overflow, erase high slots
      write_capacity(CAP_RESET);
      repeat (40) random_request(60);
      // register below the current depth: pushes refused until it drains
      write_capacity(11'd1000);
      repeat (40) random_request(50);

      // --- random capacity phases, idling switched on and off ---
      for (int phase = 0; phase < 12; phase++) begin
         k = $urandom_range(0, 5);
         case (k)
            0:       cap = 11'd0;
            1:       cap = 11'd1;
            2:       cap = cnt_type'($urandom_range(2, 16));
            3:       cap = cnt_type'($urandom_range(17, 1023));
            4:       cap = CAP_RESET;
            default: cap = 11'd2047;
         endcase
         write_capacity(cap);
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         repeat (60) random_request($urandom_range(35, 65));
      end

      // --- last part: no idling on either side ---
      write_capacity(CAP_RESET);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (150) random_request(50);

      req_valid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog: 10 ms, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
